// ===== hw/rtl/framed_bulk_transfer_receiver_defines.svh =====
// Assertion macros used by the checker of the framed bulk transfer receiver.
`ifndef FRAMED_BULK_TRANSFER_RECEIVER_DEFINES_SVH
`define FRAMED_BULK_TRANSFER_RECEIVER_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define FBTR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset cycles included.
`define FBTR_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/fbtr_pkg.sv =====
// Shared types and constants of the framed bulk transfer receiver.
`timescale 1ns / 1ps

package fbtr_pkg;

    localparam int FRAME_W = 64;
    localparam int COUNT_W = 16;

    // Input item kinds as they arrive on the stream.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_FRAME = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    // Configuration register indexes.
    localparam logic REG_FRAME_HEADER     = 1'b0;
    localparam logic REG_DATA_FRAME_COUNT = 1'b1;

    localparam logic [FRAME_W-1:0] HEADER_RESET = 64'hAA55_AA55_AA55_AA55;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 16'd1024;

    // Depths of the command queue and of the result buffer.
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int OUT_QUEUE_DEPTH = 3;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_START,
        OP_FRAME,
        OP_DRAIN
    } op_t;

    typedef enum logic [1:0] {
        PH_AWAIT = 2'd0,
        PH_SEEN  = 2'd1,
        PH_XFER  = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t                op;
        logic               hdr_match;
        logic [FRAME_W-1:0] frame_data;
    } cmd_t;

    // One result transfer.
    typedef struct packed {
        phase_t             phase;
        logic               header_error;
        logic               overflow_error;
        logic               read_valid;
        logic [FRAME_W-1:0] read_word;
    } res_t;

endpackage

// ===== hw/rtl/framed_bulk_transfer_receiver.sv =====
// Top level of the framed bulk transfer receiver.
`timescale 1ns / 1ps

// Receives a bulk transfer as 64-bit frames and keeps the data frames in a ring buffer.
// Input stream: s_tuser carries the item kind (start, frame, drain), s_tdata the frame.
// Every input transfer yields exactly one result transfer on the m_ stream, in order,
// carrying the phase, the two sticky error flags and, for a drain that finds the ring
// not empty, the oldest word with m_tuser high.
// The configuration port (cfg_wen, cfg_addr, cfg_wdata) sets the header pattern and
// the data frame count; write it only while no transfer is in flight.
// A result passes through the command queue, the result stage and the result buffer.
// Throughput: one transfer per cycle while m_tready stays high, set by the single state
// update and one ring buffer access per item in the back end.
// A two-entry command queue parts the front end from the back end, and a three-entry
// result buffer parts the back end from the output, so input is still taken while a
// result waits.
// When the receiver holds m_tready low the result buffer fills, the back end stops,
// the command queue fills and s_tready falls.
// Reset empties both queues, clears phase, pointers, counter and error flags, and loads
// the register defaults; ring buffer contents are undefined until written.

module framed_bulk_transfer_receiver import fbtr_pkg::*; #(
    parameter int RING_WORDS = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,    // frame_data[63:0]
    input  logic [1:0]         s_tuser,    // mode[1:0]
    // Result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata,    // phase[1:0], header_error[2],
                                           // overflow_error[3], read_word[67:4], zero[71:68]
    output logic               m_tuser,    // read_valid[0]
    // Configuration
    input  logic               cfg_wen,
    input  logic               cfg_addr,
    input  logic [63:0]        cfg_wdata
);

    logic [FRAME_W-1:0] header_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               front_valid;
    cmd_t               front_cmd;
    logic               q_valid, q_ready;
    cmd_t               q_cmd;
    res_t               res;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            count_reg  <= COUNT_RESET;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_FRAME_HEADER:     header_reg <= cfg_wdata;
                REG_DATA_FRAME_COUNT: count_reg  <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fbtr_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .frame_header (header_reg),
        .cmd_valid    (front_valid),
        .cmd          (front_cmd)
    );

    fbtr_queue #(
        .ITEM_T (cmd_t),
        .DEPTH  (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (s_tready),
        .push_data  (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd),
        .fill       ()
    );

    fbtr_back #(
        .RING_WORDS (RING_WORDS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .data_frame_count (count_reg),
        .cmd_valid        (q_valid),
        .cmd_ready        (q_ready),
        .cmd              (q_cmd),
        .res_valid        (m_tvalid),
        .res_ready        (m_tready),
        .res              (res)
    );

    // Pack the result transfer.
    assign m_tdata = {4'b0000, res.read_word, res.overflow_error, res.header_error,
                      res.phase};
    assign m_tuser = res.read_valid;

endmodule

// ===== hw/rtl/fbtr_queue.sv =====
// Small first-in first-out queue of typed items built from registers.
`timescale 1ns / 1ps

module fbtr_queue #(
    parameter type ITEM_T = logic,
    parameter int  DEPTH  = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push_valid,
    output logic                           push_ready,
    input  ITEM_T                          push_data,
    output logic                           pop_valid,
    input  logic                           pop_ready,
    output ITEM_T                          pop_data,
    output logic [$clog2(DEPTH+1)-1:0]     fill
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ITEM_T          slot_reg [DEPTH];
    logic [IW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign fill       = count_reg;

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Pointer wrap and occupancy.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; occupancy guards it.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/fbtr_front.sv =====
// Front end: decodes the item kind and compares the frame against the header.
`timescale 1ns / 1ps

module fbtr_front import fbtr_pkg::*; (
    input  logic               s_tvalid,
    input  logic [1:0]         s_tuser,
    input  logic [FRAME_W-1:0] s_tdata,
    input  logic [FRAME_W-1:0] frame_header,
    output logic               cmd_valid,
    output cmd_t               cmd
);

    assign cmd_valid = s_tvalid;

    // Build the command; the unused code becomes a command that only reports status.
    always_comb begin
        cmd.frame_data = s_tdata;
        cmd.hdr_match  = (s_tdata == frame_header);
        case (s_tuser)
            MODE_START: cmd.op = OP_START;
            MODE_FRAME: cmd.op = OP_FRAME;
            MODE_DRAIN: cmd.op = OP_DRAIN;
            default:    cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== hw/rtl/fbtr_back.sv =====
// Back end: transfer state, ring buffer and the result buffer.
`timescale 1ns / 1ps

module fbtr_back import fbtr_pkg::*; #(
    parameter int RING_WORDS = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [COUNT_W-1:0] data_frame_count,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res
);

    localparam int PW  = $clog2(RING_WORDS);
    localparam int OCW = $clog2(OUT_QUEUE_DEPTH + 1);

    logic [FRAME_W-1:0] ring_mem [RING_WORDS];

    phase_t             phase_reg, phase_next, phase_eff;
    logic [COUNT_W-1:0] taken_reg, taken_next;
    logic [PW-1:0]      wp_reg, wp_next, wp_after;
    logic [PW-1:0]      rp_reg, rp_next, rp_after;
    logic               herr_reg, herr_next;
    logic               ovf_reg, ovf_next;
    logic               mem_we, read_hit, exec;

    // Result stage: status and the registered ring read.
    logic               r_valid_reg;
    phase_t             r_phase_reg;
    logic               r_herr_reg, r_ovf_reg, r_hit_reg;
    logic [FRAME_W-1:0] rd_word_reg;

    res_t               ob_push;
    logic [OCW-1:0]     ob_fill;

    // Take a command only when the result buffer has room for it and the one in flight.
    assign cmd_ready = ({1'b0, ob_fill} + (OCW+1)'(r_valid_reg)) < (OCW+1)'(OUT_QUEUE_DEPTH);
    assign exec      = cmd_valid && cmd_ready;

    assign wp_after = (wp_reg == PW'(RING_WORDS - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_after = (rp_reg == PW'(RING_WORDS - 1)) ? '0 : rp_reg + 1'b1;

    // State update for one command.
    always_comb begin
        phase_next = phase_reg;
        taken_next = taken_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        herr_next  = herr_reg;
        ovf_next   = ovf_reg;
        mem_we     = 1'b0;
        read_hit   = 1'b0;
        phase_eff  = (taken_reg == '0) ? PH_XFER : phase_reg;
        case (cmd.op)
            OP_START: begin
                phase_next = PH_AWAIT;
                taken_next = '0;
                wp_next    = '0;
                rp_next    = '0;
                herr_next  = 1'b0;
                ovf_next   = 1'b0;
            end
            OP_FRAME: begin
                if (phase_reg == PH_AWAIT) begin
                    if (cmd.hdr_match) begin
                        phase_next = PH_SEEN;
                    end else begin
                        herr_next = 1'b1;
                    end
                end else begin
                    phase_next = phase_eff;
                    if (phase_eff != PH_DONE) begin
                        if (taken_reg < data_frame_count) begin
                            // Data frame: store it and check whether the ring wrapped.
                            mem_we     = 1'b1;
                            wp_next    = wp_after;
                            taken_next = taken_reg + 1'b1;
                            if (wp_after == rp_reg) begin
                                ovf_next = 1'b1;
                            end
                        end else begin
                            // Trailing header frame.
                            if (cmd.hdr_match) begin
                                phase_next = PH_DONE;
                            end else begin
                                herr_next = 1'b1;
                            end
                            taken_next = '0;
                        end
                    end
                end
            end
            OP_DRAIN: begin
                if (rp_reg != wp_reg) begin
                    read_hit = 1'b1;
                    rp_next  = rp_after;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_AWAIT;
            taken_reg   <= '0;
            wp_reg      <= '0;
            rp_reg      <= '0;
            herr_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            r_valid_reg <= 1'b0;
        end else begin
            r_valid_reg <= exec;
            if (exec) begin
                phase_reg <= phase_next;
                taken_reg <= taken_next;
                wp_reg    <= wp_next;
                rp_reg    <= rp_next;
                herr_reg  <= herr_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Result stage payload.
    always_ff @(posedge aclk) begin
        if (exec) begin
            r_phase_reg <= phase_next;
            r_herr_reg  <= herr_next;
            r_ovf_reg   <= ovf_next;
            r_hit_reg   <= read_hit;
        end
    end

    // Ring buffer: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (exec && mem_we) begin
            ring_mem[wp_reg] <= cmd.frame_data;
        end
        if (exec && read_hit) begin
            rd_word_reg <= ring_mem[rp_reg];
        end
    end

    assign ob_push.phase          = r_phase_reg;
    assign ob_push.header_error   = r_herr_reg;
    assign ob_push.overflow_error = r_ovf_reg;
    assign ob_push.read_valid     = r_hit_reg;
    assign ob_push.read_word      = r_hit_reg ? rd_word_reg : '0;

    // Result buffer; room is reserved before a command is taken.
    fbtr_queue #(
        .ITEM_T (res_t),
        .DEPTH  (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (r_valid_reg),
        .push_ready (),
        .push_data  (ob_push),
        .pop_valid  (res_valid),
        .pop_ready  (res_ready),
        .pop_data   (res),
        .fill       (ob_fill)
    );

endmodule

// ===== hw/rtl/fbtr_checker.sv =====
// Port-level checks of the framed bulk transfer receiver and their binding.
`timescale 1ns / 1ps
`include "framed_bulk_transfer_receiver_defines.svh"

module fbtr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser
);

    // No result may be offered right after a reset cycle.
    `FBTR_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !m_tvalid, "result offered after reset")

    // A result without a drained word carries a zero word.
    `FBTR_ASSERT(a_word_zero, m_tvalid && !m_tuser |-> m_tdata[67:4] == '0, "word not zero")

    // Padding above the word stays zero.
    `FBTR_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[71:68] == 4'd0), "padding not zero")

    // A stalled result holds its contents.
    `FBTR_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "held changed")

endmodule

bind framed_bulk_transfer_receiver fbtr_checker u_fbtr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/framed_bulk_transfer_receiver_tb.sv =====
// Self-checking testbench for the framed bulk transfer receiver.
`timescale 1ns / 1ps

module framed_bulk_transfer_receiver_tb;
    import fbtr_pkg::*;

    localparam int RING_DEPTH   = 128;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 9;

    // The stream carries a fourth kind that the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Tracks the receiver state and holds the result transfers still owed.
    class transfer_scoreboard;
        logic [FRAME_W-1:0] header_pattern;
        logic [COUNT_W-1:0] frame_count;
        phase_t             phase;
        logic [COUNT_W-1:0] frames_taken;
        int unsigned        wr_ptr;
        int unsigned        rd_ptr;
        logic               header_err;
        logic               overflow_err;
        logic [FRAME_W-1:0] ring_words [RING_DEPTH];
        res_t               owed_results [$];
        int                 errors;

        function new();
            header_pattern = HEADER_RESET;
            frame_count    = COUNT_RESET;
            phase          = PH_AWAIT;
            frames_taken   = '0;
            wr_ptr         = 0;
            rd_ptr         = 0;
            header_err     = 1'b0;
            overflow_err   = 1'b0;
            errors         = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // A received frame: opening header, data word or trailing header.
        function void take_frame(logic [FRAME_W-1:0] frame);
            if (phase == PH_AWAIT) begin
                if (frame == header_pattern)
                    phase = PH_SEEN;
                else
                    header_err = 1'b1;
                return;
            end
            // A fresh count means the frame opens a run of data frames.
            if (frames_taken == '0)
                phase = PH_XFER;
            if (frames_taken < frame_count) begin
                ring_words[wr_ptr] = frame;
                wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                if (wr_ptr == rd_ptr)
                    overflow_err = 1'b1;
                frames_taken = frames_taken + 1'b1;
            end else begin
                if (frame == header_pattern)
                    phase = PH_DONE;
                else
                    header_err = 1'b1;
                frames_taken = '0;
            end
        endfunction

        // Updates the state for one accepted input transfer and queues its result.
        function void note_input(logic [1:0] mode, logic [FRAME_W-1:0] frame);
            res_t r;
            r.read_valid = 1'b0;
            r.read_word  = '0;
            case (mode)
                MODE_START: begin
                    phase        = PH_AWAIT;
                    header_err   = 1'b0;
                    overflow_err = 1'b0;
                    wr_ptr       = 0;
                    rd_ptr       = 0;
                    frames_taken = '0;
                end
                MODE_FRAME: take_frame(frame);
                MODE_DRAIN: begin
                    if (rd_ptr != wr_ptr) begin
                        r.read_valid = 1'b1;
                        r.read_word  = ring_words[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    end
                end
                default: ;
            endcase
            r.phase          = phase;
            r.header_error   = header_err;
            r.overflow_error = overflow_err;
            owed_results.push_back(r);
        endfunction

        // Compares one result transfer with the oldest prediction.
        function void check_result(logic [71:0] tdata, logic tuser);
            res_t want;
            if (owed_results.size() == 0) begin
                $error("result transfer arrived with no prediction waiting");
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (tdata[1:0] !== want.phase) begin
                $error("phase: expected %0d, got %0d", want.phase, tdata[1:0]);
                errors++;
            end
            if (tdata[2] !== want.header_error) begin
                $error("header_error: expected %0b, got %0b", want.header_error, tdata[2]);
                errors++;
            end
            if (tdata[3] !== want.overflow_error) begin
                $error("overflow_error: expected %0b, got %0b", want.overflow_error, tdata[3]);
                errors++;
            end
            if (tuser !== want.read_valid) begin
                $error("read_valid: expected %0b, got %0b", want.read_valid, tuser);
                errors++;
            end
            if (tdata[67:4] !== want.read_word) begin
                $error("read_word: expected %h, got %h", want.read_word, tdata[67:4]);
                errors++;
            end
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [63:0]        s_tdata   = '0;
    logic [1:0]         s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [71:0]        m_tdata;
    logic               m_tuser;
    logic               cfg_wen   = 1'b0;
    logic               cfg_addr  = 1'b0;
    logic [63:0]        cfg_wdata = '0;

    bit                 quiet_stretch = 1'b0;
    int                 items_sent    = 0;
    int unsigned        cycle_count   = 0;
    transfer_scoreboard sb = new();

    framed_bulk_transfer_receiver #(
        .RING_WORDS(RING_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // The result side stalls at random except during the quiet stretch.
    always @(posedge aclk) begin
        m_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end

    // Every accepted result transfer is checked against the prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [FRAME_W-1:0] rand_frame();
        return {$urandom, $urandom};
    endfunction

    // A header pattern off by one bit.
    function automatic logic [FRAME_W-1:0] near_miss(input logic [FRAME_W-1:0] pattern);
        return pattern ^ (64'd1 << $urandom_range(63));
    endfunction

    // Offers one input transfer, with a random gap ahead of it, and waits until it is taken.
    task automatic send_item(input logic [1:0] mode, input logic [FRAME_W-1:0] frame);
        while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= frame;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(mode, frame);
        items_sent++;
        quiet_stretch = (items_sent >= 400 && items_sent < 600);
    endtask

    // Writes both registers once every owed result has come back.
    task automatic set_config(input logic [FRAME_W-1:0] header, input logic [COUNT_W-1:0] count);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= REG_FRAME_HEADER;
        cfg_wdata <= header;
        @(posedge aclk);
        cfg_addr  <= REG_DATA_FRAME_COUNT;
        cfg_wdata <= {48'd0, count};
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.header_pattern = header;
        sb.frame_count    = count;
    endtask

    // One transfer with random content: mostly well formed, sometimes broken or noisy.
    task automatic run_transfer(input int drain_pct);
        int unsigned data_frames;
        if ($urandom_range(9) != 0)
            send_item(MODE_START, rand_frame());
        send_item(MODE_FRAME, ($urandom_range(9) == 0) ? near_miss(sb.header_pattern)
                                                       : sb.header_pattern);
        // Very long transfers are only begun, never finished.
        data_frames = (sb.frame_count > 200) ? 40 : sb.frame_count;
        for (int unsigned i = 0; i < data_frames; i++) begin
            if ($urandom_range(99) < drain_pct)
                send_item(MODE_DRAIN, rand_frame());
            if ($urandom_range(99) < 3)
                send_item(2'($urandom_range(3)), rand_frame());
            send_item(MODE_FRAME, rand_frame());
        end
        if (data_frames == sb.frame_count)
            send_item(MODE_FRAME, ($urandom_range(9) == 0) ? near_miss(sb.header_pattern)
                                                           : sb.header_pattern);
        repeat ($urandom_range(4)) send_item(MODE_DRAIN, rand_frame());
    endtask

    initial begin
        logic [FRAME_W-1:0] hdr;
        logic [COUNT_W-1:0] count;
        int                 drain_pct;
        int                 random_start;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: ignored kind, empty drain, bad opening header, short run.
        send_item(MODE_UNUSED, '1);
        send_item(MODE_DRAIN, '0);
        send_item(MODE_FRAME, '0);
        send_item(MODE_START, '1);
        send_item(MODE_FRAME, HEADER_RESET);
        send_item(MODE_FRAME, '1);
        send_item(MODE_FRAME, '0);
        send_item(MODE_DRAIN, '0);
        send_item(MODE_DRAIN, '0);
        send_item(MODE_DRAIN, '0);
        send_item(MODE_UNUSED, '0);

        // One data frame per run: bad trailer, good trailer, frame after finish.
        set_config('1, 16'd1);
        send_item(MODE_START, '0);
        send_item(MODE_FRAME, '1);
        send_item(MODE_FRAME, 64'h0123_4567_89AB_CDEF);
        send_item(MODE_FRAME, near_miss('1));
        send_item(MODE_FRAME, 64'hFEDC_BA98_7654_3210);
        send_item(MODE_FRAME, '1);
        send_item(MODE_FRAME, 64'h8000_0000_0000_0001);
        send_item(MODE_DRAIN, '0);
        send_item(MODE_DRAIN, '0);
        send_item(MODE_DRAIN, '0);

        // Largest frame count with an all-zero header.
        set_config('0, 16'hFFFF);
        send_item(MODE_START, '0);
        send_item(MODE_FRAME, '0);
        send_item(MODE_FRAME, rand_frame());
        send_item(MODE_DRAIN, '0);

        // Random settings, each with a few transfers.
        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            if ($urandom_range(4) == 0)
                hdr = '0;
            else if ($urandom_range(3) == 0)
                hdr = '1;
            else
                hdr = rand_frame();
            drain_pct = 30;
            if ($urandom_range(5) == 0) begin
                // Long runs with hardly any drains wrap the ring.
                count     = 16'($urandom_range(200, 129));
                drain_pct = 1;
            end else if ($urandom_range(9) == 0) begin
                count = ($urandom_range(1) == 0) ? 16'd1 : 16'hFFFF;
            end else begin
                count = 16'($urandom_range(12, 1));
            end
            set_config(hdr, count);
            repeat ($urandom_range(3, 1)) run_transfer(drain_pct);
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fbtr_pkg.sv
hw/rtl/fbtr_queue.sv
hw/rtl/fbtr_front.sv
hw/rtl/fbtr_back.sv
hw/rtl/framed_bulk_transfer_receiver.sv
hw/rtl/fbtr_checker.sv
tb/framed_bulk_transfer_receiver_tb.sv
